// ----- sv/ljpf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ljpf_pkg;

   localparam int MaxAtomsDefault = 1024;
   localparam int FracBitsDefault = 24;

   localparam int OutWidth = 48;
   localparam int RegWidth = 31;
   localparam int CountWidth = 11;
   localparam int PosWidth = 32;
   localparam int IndexWidth = 10;
   localparam int CsrIndexWidth = 3;
   localparam int OpWidth = 64;
   localparam int MagWidth = OutWidth - 1;

   localparam logic [MagWidth-1:0] MagMax = {MagWidth{1'b1}};

   typedef enum logic [CsrIndexWidth-1:0] {
      REG_BOX_X = 3'd0,
      REG_BOX_Y = 3'd1,
      REG_BOX_Z = 3'd2,
      REG_SIGMA_SQUARED = 3'd3,
      REG_WELL_DEPTH = 3'd4,
      REG_ATOM_COUNT = 3'd5
   } ljpf_reg_type;

   // request to the shared multiply / divide unit
   typedef struct packed {
      logic start;
      logic is_div;
      logic [OpWidth-1:0] a;
      logic [OpWidth-1:0] b;
   } ljpf_op_type;

   // answer from the shared multiply / divide unit
   typedef struct packed {
      logic done;
      logic ovf;
      logic [OpWidth-1:0] result;
   } ljpf_res_type;

endpackage

`default_nettype wire

// ----- sv/lennard_jones_pair_force.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Lennard-Jones pair force with periodic minimum image, fixed point. A load
// word (kind 0) writes one atom position into the position memory and gives
// no result. A compute word (kind 1) for atom i walks stored atoms
// j = 0 .. min(atom_count, MAX_ATOMS)-1 and returns one result word: the
// saturated force on i, the energy of pairs with j < i and the running total
// (cleared by a compute of atom 0). One item is worked at a time. Loads to
// indexes at or above MAX_ATOMS are dropped. A compute reads i, then per
// walked atom reads memory and forms the image, then runs operations of the
// shared one-bit-per-cycle multiply / divide unit: 3 operations for the self
// pair or a zero distance, 14 for a partner above i and 15 for one below i.
// That unit sets the rate. The result sits in an output register, so a
// pending result does not block loads; a finished compute waits in its
// finish state only if the previous result is still not taken.
// Configuration words are taken at any time but must only be sent while
// the block is idle. Positions read back undefined until loaded.
module lennard_jones_pair_force #(
   parameter int MAX_ATOMS = ljpf_pkg::MaxAtomsDefault,
   parameter int FRAC_BITS = ljpf_pkg::FracBitsDefault
) (
   input wire logic clock,
   input wire logic reset,
   // configuration words
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [ljpf_pkg::CsrIndexWidth-1:0] csr_index,
   input wire logic [ljpf_pkg::RegWidth-1:0] csr_data,
   // input words
   input wire logic req_valid,
   output logic req_ready,
   input wire logic req_kind,
   input wire logic [ljpf_pkg::IndexWidth-1:0] req_atom_index,
   input wire logic signed [ljpf_pkg::PosWidth-1:0] req_pos_x,
   input wire logic signed [ljpf_pkg::PosWidth-1:0] req_pos_y,
   input wire logic signed [ljpf_pkg::PosWidth-1:0] req_pos_z,
   // result words
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic signed [ljpf_pkg::OutWidth-1:0] rsp_force_x,
   output logic signed [ljpf_pkg::OutWidth-1:0] rsp_force_y,
   output logic signed [ljpf_pkg::OutWidth-1:0] rsp_force_z,
   output logic signed [ljpf_pkg::OutWidth-1:0] rsp_pair_energy,
   output logic signed [ljpf_pkg::OutWidth-1:0] rsp_total_energy
);

   import ljpf_pkg::*;

   localparam int AW = $clog2(MAX_ATOMS);
   localparam int CW = $clog2(MAX_ATOMS + 1);
   localparam int DW = 35;   // image-corrected difference
   localparam int MW = 34;   // its magnitude
   localparam int EW = 37;   // working width of the image step

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_LATCH  = 8'b0000_0010,
      S_READ   = 8'b0000_0100,
      S_DIFF   = 8'b0000_1000,
      S_IMAGE  = 8'b0001_0000,
      S_START  = 8'b0010_0000,
      S_WAIT   = 8'b0100_0000,
      S_FINISH = 8'b1000_0000
   } state_type;

   // operation steps of one pair
   typedef enum logic [8:0] {
      P_R2  = 9'b0_0000_0001,
      P_S2  = 9'b0_0000_0010,
      P_T   = 9'b0_0000_0100,
      P_S6  = 9'b0_0000_1000,
      P_S12 = 9'b0_0001_0000,
      P_H   = 9'b0_0010_0000,
      P_W   = 9'b0_0100_0000,
      P_F   = 9'b0_1000_0000,
      P_PE  = 9'b1_0000_0000
   } step_type;

   function automatic logic signed [OutWidth-1:0] sadd(
      input logic signed [OutWidth-1:0] x,
      input logic signed [OutWidth-1:0] y
   );
      logic signed [OutWidth:0] s;
      s = {x[OutWidth-1], x} + {y[OutWidth-1], y};
      if (s[OutWidth] != s[OutWidth-1]) begin
         sadd = s[OutWidth] ? {1'b1, {MagWidth{1'b0}}} : {1'b0, MagMax};
      end else begin
         sadd = s[OutWidth-1:0];
      end
   endfunction

   function automatic logic signed [OutWidth-1:0] signed_mag(
      input logic neg,
      input logic [MagWidth-1:0] m
   );
      signed_mag = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
   endfunction

   // configuration registers
   logic [RegWidth-1:0] box_ff [3];
   logic [RegWidth-1:0] sigma_ff;
   logic [RegWidth-1:0] well_ff;
   logic [CountWidth-1:0] count_ff;

   state_type state_ff, state_in;
   step_type step_ff, step_in;
   logic [1:0] axis_ff, axis_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] n_ff, n_in;
   logic [IndexWidth-1:0] i_ff, i_in;
   logic upd_ff, upd_in;

   logic signed [PosWidth-1:0] ri_ff [3];
   logic signed [PosWidth:0] draw_ff [3];
   logic signed [DW-1:0] d_ff [3];
   logic [OpWidth-1:0] r2_ff, r2_in;
   logic [OpWidth-1:0] s2_ff;
   logic [MagWidth-1:0] t_ff, s6_ff, s12_ff, hmag_ff, fmag;
   logic hneg_ff;
   logic [OpWidth-1:0] wmag_ff;
   logic signed [OutWidth-1:0] force_ff [3];
   logic signed [OutWidth-1:0] pe_ff;
   logic signed [OutWidth-1:0] energy_ff;

   logic rsp_valid_ff;
   logic signed [OutWidth-1:0] rsp_force_ff [3];
   logic signed [OutWidth-1:0] rsp_pe_ff;

   // ram
   logic ram_we;
   logic [AW-1:0] ram_raddr;
   logic [3*PosWidth-1:0] ram_rdata;

   ljpf_op_type op;
   ljpf_res_type res;

   logic req_fire, in_range;
   logic [MW-1:0] m_sel;
   logic d_neg_sel;
   logic [OpWidth-1:0] mulq;
   logic [OpWidth-1:0] prod_sh;
   logic signed [OutWidth:0] hv;
   logic [OutWidth-1:0] hv_mag;
   logic signed [OutWidth-1:0] ev;
   logic [OutWidth-1:0] ev_mag;
   logic [35:0] e24;
   logic [32:0] e4;
   logic skip_pair;
   logic out_free;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire = req_valid && req_ready;
   assign in_range = 32'(req_atom_index) < MAX_ATOMS;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff[0] <= RegWidth'(1) << FRAC_BITS;
         box_ff[1] <= RegWidth'(1) << FRAC_BITS;
         box_ff[2] <= RegWidth'(1) << FRAC_BITS;
         sigma_ff <= RegWidth'(1) << FRAC_BITS;
         well_ff <= RegWidth'(1) << FRAC_BITS;
         count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_BOX_X: box_ff[0] <= csr_data;
            REG_BOX_Y: box_ff[1] <= csr_data;
            REG_BOX_Z: box_ff[2] <= csr_data;
            REG_SIGMA_SQUARED: sigma_ff <= csr_data;
            REG_WELL_DEPTH: well_ff <= csr_data;
            REG_ATOM_COUNT: count_ff <= csr_data[CountWidth-1:0];
            default: ;
         endcase
      end
   end

   // position memory: x, y, z packed in one word
   assign ram_we = req_fire && !req_kind && in_range;
   assign ram_raddr = (state_ff == S_IDLE) ? AW'(req_atom_index) : AW'(j_ff);

   ljpf_ram #(
      .WIDTH(3 * PosWidth),
      .DEPTH(MAX_ATOMS)
   ) u_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(AW'(req_atom_index)),
      .wdata({req_pos_z, req_pos_y, req_pos_x}),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   ljpf_arith u_arith (
      .clock(clock),
      .reset(reset),
      .op(op),
      .res(res)
   );

   // operand selection for the shared unit
   always_comb begin
      m_sel = '0;
      d_neg_sel = 1'b0;
      case (axis_ff)
         2'd0: begin
            d_neg_sel = d_ff[0] < 0;
            m_sel = MW'(d_neg_sel ? -d_ff[0] : d_ff[0]);
         end
         2'd1: begin
            d_neg_sel = d_ff[1] < 0;
            m_sel = MW'(d_neg_sel ? -d_ff[1] : d_ff[1]);
         end
         default: begin
            d_neg_sel = d_ff[2] < 0;
            m_sel = MW'(d_neg_sel ? -d_ff[2] : d_ff[2]);
         end
      endcase

      e24 = {1'b0, well_ff, 4'b0} + {2'b0, well_ff, 3'b0};
      e4 = {well_ff, 2'b0};
      hv = $signed({1'b0, s12_ff, 1'b0}) - $signed({2'b0, s6_ff});
      hv_mag = OutWidth'(hv < 0 ? -hv : hv);
      ev = $signed({1'b0, s12_ff}) - $signed({1'b0, s6_ff});
      ev_mag = ev < 0 ? -ev : ev;

      op.start = (state_ff == S_START);
      op.is_div = 1'b0;
      op.a = '0;
      op.b = '0;
      case (step_ff)
         P_R2: begin
            op.a = OpWidth'(m_sel);
            op.b = OpWidth'(m_sel);
         end
         P_S2: begin
            op.is_div = 1'b1;
            op.a = OpWidth'(sigma_ff) << FRAC_BITS;
            op.b = r2_ff;
         end
         P_T: begin
            op.a = s2_ff;
            op.b = s2_ff;
         end
         P_S6: begin
            op.a = OpWidth'(t_ff);
            op.b = s2_ff;
         end
         P_S12: begin
            op.a = OpWidth'(s6_ff);
            op.b = OpWidth'(s6_ff);
         end
         P_H: begin
            op.a = OpWidth'(e24);
            op.b = OpWidth'(hv_mag);
         end
         P_W: begin
            op.is_div = 1'b1;
            op.a = OpWidth'(m_sel) << FRAC_BITS;
            op.b = r2_ff;
         end
         P_F: begin
            op.a = OpWidth'(hmag_ff);
            op.b = wmag_ff;
         end
         P_PE: begin
            op.a = OpWidth'(e4);
            op.b = OpWidth'(ev_mag);
         end
         default: ;
      endcase
   end

   // fixed-point product: scale down, then saturate on overflow past 64 bits or past MagWidth bits
   assign prod_sh = res.result >> FRAC_BITS;
   assign mulq = (res.ovf || prod_sh > OpWidth'(MagMax)) ? OpWidth'(MagMax) : prod_sh;
   assign fmag = mulq[MagWidth-1:0];
   assign r2_in = r2_ff + prod_sh;
   assign skip_pair = (32'(j_ff) == 32'(i_ff)) || (r2_in == '0);

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      axis_in = axis_ff;
      j_in = j_ff;
      n_in = n_ff;
      i_in = i_ff;
      upd_in = upd_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_kind) begin
               i_in = req_atom_index;
               j_in = '0;
               n_in = (32'(count_ff) > MAX_ATOMS) ? CW'(MAX_ATOMS) : CW'(count_ff);
               upd_in = in_range;
               state_in = in_range ? S_LATCH : S_FINISH;
            end
         end
         S_LATCH: state_in = S_READ;
         S_READ: state_in = (j_ff == n_ff) ? S_FINISH : S_DIFF;
         S_DIFF: state_in = S_IMAGE;
         S_IMAGE: begin
            step_in = P_R2;
            axis_in = 2'd0;
            state_in = S_START;
         end
         S_START: state_in = S_WAIT;
         S_WAIT: begin
            if (res.done) begin
               state_in = S_START;
               case (step_ff)
                  P_R2: begin
                     if (axis_ff != 2'd2) begin
                        axis_in = axis_ff + 2'd1;
                     end else if (skip_pair) begin
                        j_in = j_ff + CW'(1);
                        state_in = S_READ;
                     end else begin
                        step_in = P_S2;
                     end
                  end
                  P_S2: step_in = P_T;
                  P_T: step_in = P_S6;
                  P_S6: step_in = P_S12;
                  P_S12: step_in = P_H;
                  P_H: begin
                     step_in = P_W;
                     axis_in = 2'd0;
                  end
                  P_W: step_in = P_F;
                  P_F: begin
                     if (axis_ff != 2'd2) begin
                        axis_in = axis_ff + 2'd1;
                        step_in = P_W;
                     end else if (32'(j_ff) < 32'(i_ff)) begin
                        step_in = P_PE;
                     end else begin
                        j_in = j_ff + CW'(1);
                        state_in = S_READ;
                     end
                  end
                  P_PE: begin
                     j_in = j_ff + CW'(1);
                     state_in = S_READ;
                  end
                  default: ;
               endcase
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= P_R2;
         axis_ff <= '0;
         j_ff <= '0;
         n_ff <= '0;
         i_ff <= '0;
         upd_ff <= 1'b0;
         energy_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         axis_ff <= axis_in;
         j_ff <= j_in;
         n_ff <= n_in;
         i_ff <= i_in;
         upd_ff <= upd_in;
         if (state_ff == S_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
            if (upd_ff) begin
               energy_ff <= (i_ff == '0) ? pe_ff : sadd(energy_ff, pe_ff);
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      logic signed [EW-1:0] bx, dd;
      if (state_ff == S_IDLE && req_fire && req_kind) begin
         for (int u = 0; u < 3; u++) begin
            force_ff[u] <= '0;
         end
         pe_ff <= '0;
      end
      if (state_ff == S_LATCH) begin
         ri_ff[0] <= ram_rdata[PosWidth-1:0];
         ri_ff[1] <= ram_rdata[2*PosWidth-1:PosWidth];
         ri_ff[2] <= ram_rdata[3*PosWidth-1:2*PosWidth];
      end
      if (state_ff == S_DIFF) begin
         for (int u = 0; u < 3; u++) begin
            draw_ff[u] <= $signed({ram_rdata[(u+1)*PosWidth-1], ram_rdata[u*PosWidth +: PosWidth]})
                          - $signed({ri_ff[u][PosWidth-1], ri_ff[u]});
         end
      end
      if (state_ff == S_IMAGE) begin
         for (int u = 0; u < 3; u++) begin
            bx = $signed(EW'(box_ff[u]));
            dd = EW'(draw_ff[u]);
            if ((dd <<< 1) > bx) begin
               dd = dd - bx;
            end
            if ((dd <<< 1) <= -bx) begin
               dd = dd + bx;
            end
            d_ff[u] <= DW'(dd);
         end
         r2_ff <= '0;
      end
      if (state_ff == S_WAIT && res.done) begin
         case (step_ff)
            P_R2: r2_ff <= r2_in;
            P_S2: s2_ff <= res.result;
            P_T: t_ff <= fmag;
            P_S6: s6_ff <= fmag;
            P_S12: s12_ff <= fmag;
            P_H: begin
               hmag_ff <= fmag;
               hneg_ff <= hv < 0;
            end
            P_W: wmag_ff <= res.result;
            P_F: force_ff[axis_ff] <= sadd(force_ff[axis_ff],
                                          signed_mag(!(hneg_ff ^ d_neg_sel), fmag));
            P_PE: pe_ff <= sadd(pe_ff, signed_mag(ev < 0, fmag));
            default: ;
         endcase
      end
      if (state_ff == S_FINISH && out_free) begin
         for (int u = 0; u < 3; u++) begin
            rsp_force_ff[u] <= force_ff[u];
         end
         rsp_pe_ff <= pe_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_force_x = rsp_force_ff[0];
   assign rsp_force_y = rsp_force_ff[1];
   assign rsp_force_z = rsp_force_ff[2];
   assign rsp_pair_energy = rsp_pe_ff;
   assign rsp_total_energy = energy_ff;

endmodule

`default_nettype wire

// ----- sv/ljpf_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ljpf_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 1024
) (
   input wire logic clock,
   input wire logic we,
   input wire logic [$clog2(DEPTH)-1:0] waddr,
   input wire logic [WIDTH-1:0] wdata,
   input wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

// ----- sv/ljpf_arith.sv -----
`timescale 1ns / 1ps
`default_nettype none

// shared unit: 64-bit shift-add multiply (low word plus overflow flag)
// or restoring divide, one bit per cycle
module ljpf_arith (
   input wire logic clock,
   input wire logic reset,
   input wire ljpf_pkg::ljpf_op_type op,
   output ljpf_pkg::ljpf_res_type res
);

   import ljpf_pkg::*;

   logic busy_ff;
   logic done_ff;
   logic [5:0] cnt_ff;
   logic is_div_ff;
   logic ovf_ff, ovf_in;
   logic [OpWidth-1:0] a_ff;
   logic [OpWidth-1:0] b_ff, b_in;
   logic [OpWidth-1:0] acc_ff, acc_in;
   logic [OpWidth:0] rem_ff, rem_in;

   logic [OpWidth:0] mul_sum;
   logic [OpWidth:0] rem_sh;
   logic q_bit;

   always_comb begin
      mul_sum = {1'b0, acc_ff[OpWidth-2:0], 1'b0} + {1'b0, (b_ff[OpWidth-1] ? a_ff : '0)};
      rem_sh = {rem_ff[OpWidth-1:0], acc_ff[OpWidth-1]};
      q_bit = (rem_sh >= {1'b0, b_ff});
      if (is_div_ff) begin
         acc_in = {acc_ff[OpWidth-2:0], q_bit};
         rem_in = q_bit ? rem_sh - {1'b0, b_ff} : rem_sh;
         b_in = b_ff;
         ovf_in = ovf_ff;
      end else begin
         acc_in = mul_sum[OpWidth-1:0];
         rem_in = rem_ff;
         b_in = {b_ff[OpWidth-2:0], 1'b0};
         ovf_in = ovf_ff | acc_ff[OpWidth-1] | mul_sum[OpWidth];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (op.start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '1;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (op.start) begin
         is_div_ff <= op.is_div;
         a_ff <= op.a;
         b_ff <= op.b;
         acc_ff <= op.is_div ? op.a : '0;
         rem_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         b_ff <= b_in;
         rem_ff <= rem_in;
         ovf_ff <= ovf_in;
      end
   end

   assign res.done = done_ff;
   assign res.ovf = ovf_ff;
   assign res.result = acc_ff;

endmodule

`default_nettype wire

// ----- sv/ljpf_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ljpf_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic req_kind,
   input wire logic rsp_valid,
   input wire logic rsp_ready
);

   // a compute word takes the block out of idle, so ready drops
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind |=> !req_ready)
      else $error("ready stayed high after a compute word");

   // a load word never brings a result of its own
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_kind && !rsp_valid |=> !rsp_valid)
      else $error("result after a load word");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

endmodule

bind lennard_jones_pair_force ljpf_checker u_ljpf_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_kind(req_kind),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready)
);

`default_nettype wire
